[rtl/strt_pkg.sv]
package strt_pkg;

  localparam int BYTE_W     = 8;
  localparam int COL_W      = 16;
  localparam int MARK_W     = COL_W + 1;
  localparam int PEND_W     = 16;
  localparam int REP_W      = 8;
  localparam int FM_W       = 2;
  localparam int TH_W       = 3;
  localparam int IDX_W      = 3;
  localparam int DATA_W     = 16;
  localparam int NUM_STOPS  = 4;
  localparam int EXPAND_W   = 8;
  localparam int EXP_SHIFT  = $clog2(EXPAND_W);
  localparam int STEP_W     = $clog2(COL_W);
  localparam int NUM_LANES  = 3;
  localparam int LANE_TOP   = 0;
  localparam int LANE_COL   = 1;
  localparam int LANE_NEXT  = 2;
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [PEND_W-1:0] PEND_MAX = '1;
  localparam logic [REP_W-1:0]  REP_RESET = 8'd8;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;

  localparam logic [IDX_W-1:0] REG_FIELD_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_TAB_HANDLING = 3'd1;
  localparam logic [IDX_W-1:0] REG_REPEAT       = 3'd2;
  localparam logic [IDX_W-1:0] REG_STOP_ZERO    = 3'd3;
  localparam logic [IDX_W-1:0] REG_STOP_LAST    = IDX_W'(REG_STOP_ZERO + NUM_STOPS - 1);

  localparam logic [FM_W-1:0] FM_FIXED    = 2'd1;
  localparam logic [FM_W-1:0] FM_COMPRESS = 2'd2;

  localparam logic [TH_W-1:0] TH_HONOUR = 3'd1;
  localparam logic [TH_W-1:0] TH_DELETE = 3'd2;
  localparam logic [TH_W-1:0] TH_PASS   = 3'd3;
  localparam logic [TH_W-1:0] TH_SPACE  = 3'd4;
  localparam logic [TH_W-1:0] TH_EXPAND = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [PEND_W-1:0] out_count;
    logic              last_of_run;
  } rec_t;

endpackage

[rtl/strt_in_if.sv]
interface strt_in_if import strt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[rtl/strt_out_if.sv]
interface strt_out_if import strt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [PEND_W-1:0] out_count;
  logic              last_of_run;

  modport source (output valid, output out_byte, output out_count, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input out_count, input last_of_run,
                output ready);
endinterface

[rtl/space_run_to_tab_encoder_unit.sv]
// Space-run to tab encoder. One text byte is taken per cycle into an input register and
// processed once the result queue holds at most one result; its results (zero to three
// space, tab or byte runs) go into a four-entry result queue that drains one result per
// cycle while the consumer is ready. The input keeps taking a byte every cycle as long as
// the queue holds at most one result and the remainder unit is idle; bytes that cause two
// or three results hold the input until the queue has drained back to one result. The
// repeating tab stops are tracked by running multiples of the repeat interval, which are
// rebuilt by a bit-serial remainder unit after every configuration write: the input is
// held off while that unit runs after the last write of a burst.
module space_run_to_tab_encoder_unit import strt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [DATA_W-1:0] wr_data,
  strt_in_if.sink          text_in,
  strt_out_if.source       code_out
);

  // configuration
  logic [FM_W-1:0]  field_mode;
  logic [TH_W-1:0]  tab_handling;
  logic [REP_W-1:0] repeat_interval;
  logic [COL_W-1:0] stop_list [NUM_STOPS];

  // line state
  logic [COL_W-1:0]  column, column_next;
  logic [COL_W-1:0]  next_stop, next_stop_next;
  logic [PEND_W-1:0] pending, pending_next;
  logic [MARK_W-1:0] rmark, rmark_next;
  logic [MARK_W-1:0] rtop;
  logic [MARK_W-1:0] rjump;
  logic              stale, stale_next;

  // remainder unit
  logic              busy;
  logic [STEP_W-1:0] step_cnt;
  logic [REP_W-1:0]  rem [NUM_LANES];
  logic [REP_W-1:0]  rem_next [NUM_LANES];
  logic [COL_W-1:0]  lane_base [NUM_LANES];
  logic [MARK_W-1:0] lane_mark [NUM_LANES];
  logic [COL_W-1:0]  stop_top;
  logic [STEP_W-1:0] bit_idx;

  // input register
  logic              in_q_valid;
  logic [BYTE_W-1:0] in_q_byte;
  logic              fire;

  // result queue
  rec_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fifo_cnt;
  logic               pop;

  // step logic
  logic [REP_W-1:0]   rep_e;
  logic [COL_W-1:0]   col_inc;
  logic [MARK_W-1:0]  exp_sum, exp_round;
  logic [COL_W-1:0]   exp_t;
  logic               is_space, is_tab, is_nl;
  logic               hon, pass_t, other, search, hit, past;
  logic               found;
  logic [COL_W-1:0]   best;
  logic [MARK_W-1:0]  adv, cand;
  rec_t               e_rec [MAX_RES];
  logic               e_v [MAX_RES];
  logic [FIFO_AW-1:0] e_off [MAX_RES];
  logic [1:0]         push_n;

  function automatic logic [PEND_W-1:0] pend_add(input logic [PEND_W-1:0] p,
                                                 input logic [COL_W-1:0] k);
    logic [PEND_W:0] s;
    s = (PEND_W+1)'(p) + (PEND_W+1)'(k);
    return s[PEND_W] ? PEND_MAX : s[PEND_W-1:0];
  endfunction

  assign rep_e    = (repeat_interval == '0) ? REP_W'(1) : repeat_interval;
  assign fire     = in_q_valid && (fifo_cnt <= CNT_W'(FIFO_DEPTH - MAX_RES));
  assign text_in.ready = !busy && (!in_q_valid || fire);

  assign is_space = (in_q_byte == CH_SPACE);
  assign is_tab   = (in_q_byte == CH_TAB);
  assign is_nl    = (in_q_byte == CH_NL);

  assign col_inc   = (column == COL_MAX) ? column : column + COL_W'(1);
  assign exp_sum   = {1'b0, col_inc} + MARK_W'(EXPAND_W - 1);
  assign exp_round = (exp_sum >> EXP_SHIFT) << EXP_SHIFT;
  assign exp_t     = (exp_round > {1'b0, COL_MAX}) ? COL_MAX : exp_round[COL_W-1:0];

  always_comb begin
    column_next  = column;
    pending_next = pending;
    search       = 1'b0;
    hon          = 1'b0;
    pass_t       = 1'b0;
    other        = 1'b0;
    if (is_space) begin
      column_next  = col_inc;
      pending_next = pend_add(pending, COL_W'(1));
    end else if (is_tab) begin
      case (tab_handling)
        TH_HONOUR: begin
          hon          = 1'b1;
          pending_next = '0;
          column_next  = (next_stop != '0) ? next_stop : col_inc;
          search       = 1'b1;
        end
        TH_DELETE: begin
          column_next = column;
        end
        TH_PASS: begin
          pass_t       = 1'b1;
          column_next  = col_inc;
          pending_next = '0;
        end
        TH_SPACE: begin
          column_next  = col_inc;
          pending_next = pend_add(pending, COL_W'(1));
        end
        TH_EXPAND: begin
          column_next = exp_t;
          if (exp_t > column) begin
            pending_next = pend_add(pending, exp_t - column);
          end
        end
        default: begin
          column_next = col_inc;
        end
      endcase
    end else begin
      other        = 1'b1;
      column_next  = col_inc;
      pending_next = '0;
      if (is_nl) begin
        column_next = '0;
        search      = 1'b1;
      end
    end

    hit  = !search && (next_stop != '0) && (column_next == next_stop);
    past = !search && (next_stop != '0) && (column_next > next_stop);

    // emitted runs, in output order
    e_v[0]             = (pass_t || other) && (pending != '0);
    e_rec[0].out_byte  = CH_SPACE;
    e_rec[0].out_count = pending;
    e_v[1]             = hon || pass_t || other;
    e_rec[1].out_byte  = other ? in_q_byte : CH_TAB;
    e_rec[1].out_count = PEND_W'(1);
    e_v[2]             = hit && ((field_mode == FM_FIXED) || (pending_next != '0));
    e_rec[2].out_byte  = ((pending_next == PEND_W'(1)) && (field_mode == FM_COMPRESS)) ?
                         CH_SPACE : CH_TAB;
    e_rec[2].out_count = PEND_W'(1);
    e_rec[2].last_of_run = 1'b1;
    e_rec[1].last_of_run = !e_v[2];
    e_rec[0].last_of_run = !e_v[1] && !e_v[2];
    e_off[0] = '0;
    e_off[1] = FIFO_AW'(e_v[0]);
    e_off[2] = FIFO_AW'(e_v[0]) + FIFO_AW'(e_v[1]);
    push_n   = 2'(e_v[0]) + 2'(e_v[1]) + 2'(e_v[2]);
    if (hit) begin
      pending_next = '0;
    end

    // running multiple of the repeat interval past the new column
    adv = rmark;
    for (int j = EXPAND_W; j >= 1; j--) begin
      cand = rmark + MARK_W'(rep_e) * MARK_W'(j);
      if (cand > {1'b0, column_next}) begin
        adv = cand;
      end
    end
    if (other && is_nl) begin
      rmark_next = rtop;
    end else if (hon && stale && (next_stop != '0)) begin
      rmark_next = rjump;
    end else if ({1'b0, column_next} >= rmark) begin
      rmark_next = adv;
    end else begin
      rmark_next = rmark;
    end

    // nearest listed stop past the new column
    found = 1'b0;
    best  = COL_MAX;
    for (int i = 0; i < NUM_STOPS; i++) begin
      if ((stop_list[i] != '0) && (stop_list[i] > column_next) &&
          (!found || (stop_list[i] < best))) begin
        best  = stop_list[i];
        found = 1'b1;
      end
    end

    if (search || hit || past) begin
      if (found) begin
        next_stop_next = best;
      end else if (rmark_next > {1'b0, COL_MAX}) begin
        next_stop_next = '0;
      end else begin
        next_stop_next = rmark_next[COL_W-1:0];
      end
      stale_next = 1'b0;
    end else begin
      next_stop_next = next_stop;
      stale_next     = stale;
    end
  end

  // remainder unit: base mod interval, one base bit per cycle
  assign bit_idx = STEP_W'(COL_W - 1) - step_cnt;

  always_comb begin
    logic [REP_W:0] shifted;
    logic [REP_W:0] diff;
    stop_top = '0;
    for (int i = 0; i < NUM_STOPS; i++) begin
      if (stop_list[i] > stop_top) begin
        stop_top = stop_list[i];
      end
    end
    lane_base[LANE_TOP]  = stop_top;
    lane_base[LANE_COL]  = (column > stop_top) ? column : stop_top;
    lane_base[LANE_NEXT] = (next_stop > stop_top) ? next_stop : stop_top;
    for (int l = 0; l < NUM_LANES; l++) begin
      shifted = {rem[l], lane_base[l][bit_idx]};
      diff    = shifted - {1'b0, rep_e};
      rem_next[l]  = (shifted >= {1'b0, rep_e}) ? diff[REP_W-1:0] : shifted[REP_W-1:0];
      lane_mark[l] = {1'b0, lane_base[l]} - MARK_W'(rem_next[l]) + MARK_W'(rep_e);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem[l] <= '0;
      end
    end else if (busy) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem[l] <= rem_next[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_mode      <= '0;
      tab_handling    <= '0;
      repeat_interval <= REP_RESET;
      for (int i = 0; i < NUM_STOPS; i++) begin
        stop_list[i] <= '0;
      end
      column    <= '0;
      next_stop <= COL_W'(REP_RESET);
      pending   <= '0;
      rmark     <= MARK_W'(REP_RESET);
      rtop      <= MARK_W'(REP_RESET);
      rjump     <= MARK_W'(REP_RESET);
      stale     <= 1'b0;
      busy      <= 1'b0;
      step_cnt  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FIELD_MODE:   field_mode      <= wr_data[FM_W-1:0];
        REG_TAB_HANDLING: tab_handling    <= wr_data[TH_W-1:0];
        REG_REPEAT:       repeat_interval <= wr_data[REP_W-1:0];
        default: begin
          if (wr_index inside {[REG_STOP_ZERO:REG_STOP_LAST]}) begin
            stop_list[$clog2(NUM_STOPS)'(wr_index - REG_STOP_ZERO)] <= wr_data[COL_W-1:0];
          end
        end
      endcase
      busy     <= 1'b1;
      step_cnt <= '0;
    end else if (busy) begin
      step_cnt <= step_cnt + STEP_W'(1);
      if (step_cnt == STEP_W'(COL_W - 1)) begin
        busy  <= 1'b0;
        rtop  <= lane_mark[LANE_TOP];
        rmark <= lane_mark[LANE_COL];
        rjump <= lane_mark[LANE_NEXT];
        stale <= 1'b1;
      end
    end else if (fire) begin
      column    <= column_next;
      next_stop <= next_stop_next;
      pending   <= pending_next;
      rmark     <= rmark_next;
      stale     <= stale_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (text_in.valid && text_in.ready) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      in_q_byte <= text_in.in_byte;
    end
  end

  // result queue
  assign pop = code_out.valid && code_out.ready;

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (e_v[k]) begin
          fifo_mem[wr_ptr + e_off[k]] <= e_rec[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (fire) begin
        wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_cnt <= fifo_cnt + (fire ? CNT_W'(push_n) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

  assign code_out.valid       = (fifo_cnt != '0);
  assign code_out.out_byte    = fifo_mem[rd_ptr].out_byte;
  assign code_out.out_count   = fifo_mem[rd_ptr].out_count;
  assign code_out.last_of_run = fifo_mem[rd_ptr].last_of_run;

endmodule
